FILE: hw/rtl/hyp3_pkg.sv
// shared constants, codes and payload types of the three-component norm unit
// no dependencies
`default_nettype none

package hyp3_pkg;

    typedef logic [30:0] mag_t;
    typedef logic [1:0]  scale_t;

    typedef struct packed {
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] z_bits;
    } vec_t;

    typedef struct packed {
        logic [31:0] norm_bits;
    } norm_t;

    localparam mag_t        INF_MAG    = 31'h7F800000;
    localparam logic [31:0] QNAN_BITS  = 32'h7FC00000;
    localparam mag_t        SCALE_DOWN = 31'h1F800000;
    localparam mag_t        SCALE_UP   = 31'h5F800000;
    localparam mag_t        SCALE_ONE  = 31'h3F800000;
    localparam logic [7:0]  HIGH_EXPO  = 8'd191;
    localparam logic [7:0]  LOW_EXPO   = 8'd77;

    localparam scale_t SC_NONE = 2'd0;
    localparam scale_t SC_DOWN = 2'd1;
    localparam scale_t SC_UP   = 2'd2;

    localparam int MUL_LAT  = 3;
    localparam int ADD_LAT  = 3;
    localparam int SQRT_LAT = 27;

    localparam int PRE_OUT  = MUL_LAT;
    localparam int SQ_OUT   = PRE_OUT + MUL_LAT;
    localparam int ROOT_OUT = SQ_OUT + 2 * ADD_LAT + SQRT_LAT;
    localparam int LAST_STG = ROOT_OUT + MUL_LAT;

endpackage

`default_nettype wire

FILE: hw/rtl/hyp3_chan_if.sv
// valid/ready channel carrying one request payload
// no dependencies
`default_nettype none

interface hyp3_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hyp3_fmul.sv
// three-stage single-precision multiply of non-negative magnitudes, nearest even
// depends on hyp3_pkg
`default_nettype none

module hyp3_fmul (
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] a,
    input  logic [30:0] b,
    output logic [30:0] y
);
    import hyp3_pkg::*;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
                n = 6'(47 - i);
        end
        return n;
    endfunction

    logic [47:0]        prod_reg;
    logic [9:0]         esum_reg;
    logic               inf1_reg;
    logic [47:0]        prod2_reg;
    logic signed [10:0] sh2_reg;
    logic [8:0]         efm1_reg;
    logic               inf2_reg;
    logic               zero2_reg;
    logic [30:0]        y_reg;

    logic [7:0]         ea, eb;
    logic [23:0]        ma, mb;
    logic [47:0]        prod_next;
    logic [9:0]         esum_next;
    logic               inf1_next;

    logic [5:0]         lz;
    logic signed [10:0] e_norm;
    logic signed [10:0] sh_next;
    logic [8:0]         efm1_next;

    logic [10:0]        neg_sh;
    logic [5:0]         rsh;
    logic [95:0]        wide;
    logic [47:0]        q;
    logic               st;
    logic [23:0]        m24;
    logic               inc;
    logic [32:0]        packed_val;
    logic [30:0]        y_next;

    // stage 1: unpack and multiply
    always_comb
    begin
        ea        = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb        = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma        = {|a[30:23], a[22:0]};
        mb        = {|b[30:23], b[22:0]};
        prod_next = 48'(ma) * 48'(mb);
        esum_next = 10'(ea) + 10'(eb);
        inf1_next = (&a[30:23]) | (&b[30:23]);
    end

    // stage 2: leading-zero search and exponent
    always_comb
    begin
        lz     = lzc48(prod_reg);
        e_norm = $signed({1'b0, esum_reg}) - 11'sd126 - $signed({5'b0, lz});
        if (e_norm > 11'sd0)
        begin
            sh_next   = $signed({5'b0, lz});
            efm1_next = 9'(e_norm - 11'sd1);
        end
        else
        begin
            sh_next   = $signed({5'b0, lz}) + e_norm - 11'sd1;
            efm1_next = '0;
        end
    end

    // stage 3: shift, round, pack
    always_comb
    begin
        neg_sh = 11'(-sh2_reg);
        rsh    = (neg_sh > 11'd49) ? 6'd49 : neg_sh[5:0];
        wide   = {prod2_reg, 48'b0} >> rsh;
        if (!sh2_reg[10])
        begin
            q  = prod2_reg << sh2_reg[5:0];
            st = 1'b0;
        end
        else
        begin
            q  = wide[95:48];
            st = |wide[47:0];
        end
        m24        = q[47:24];
        inc        = q[23] & (st | (|q[22:0]) | m24[0]);
        packed_val = {1'b0, efm1_reg, 23'b0} + {9'b0, m24} + {32'b0, inc};
        if (inf2_reg || packed_val >= {2'b0, INF_MAG})
            y_next = INF_MAG;
        else if (zero2_reg)
            y_next = '0;
        else
            y_next = packed_val[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            esum_reg  <= esum_next;
            inf1_reg  <= inf1_next;
            prod2_reg <= prod_reg;
            sh2_reg   <= sh_next;
            efm1_reg  <= efm1_next;
            inf2_reg  <= inf1_reg;
            zero2_reg <= (prod_reg == 48'd0);
            y_reg     <= y_next;
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/hyp3_sumsqrt.sv
// sum of three squares, two pipelined adds, then a correctly rounded
// pipelined square root, one root bit per stage; depends on hyp3_pkg
`default_nettype none

module hyp3_sumsqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] sx,
    input  logic [30:0] sy,
    input  logic [30:0] sz,
    output logic [30:0] root
);
    import hyp3_pkg::*;

    localparam int SQ_W    = 51;
    localparam int SQ_ITER = 25;

    typedef struct packed {
        logic [7:0]  ebig;
        logic [23:0] mbig;
        logic [23:0] msm;
        logic [7:0]  d;
        logic        inf;
    } align_t;

    typedef struct packed {
        logic [27:0] sum;
        logic [7:0]  ebig;
        logic        inf;
    } addsum_t;

    typedef struct packed {
        logic [49:0] big;
        logic [7:0]  rexp;
        logic        zero;
        logic        inf;
    } prep_t;

    function automatic align_t add_align(input logic [30:0] a, input logic [30:0] b);
        logic [30:0] hi, lo;
        logic [7:0]  eh, el;
        align_t      r;
        hi     = (a >= b) ? a : b;
        lo     = (a >= b) ? b : a;
        eh     = (hi[30:23] == 8'd0) ? 8'd1 : hi[30:23];
        el     = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
        r.ebig = eh;
        r.mbig = {|hi[30:23], hi[22:0]};
        r.msm  = {|lo[30:23], lo[22:0]};
        r.d    = eh - el;
        r.inf  = &hi[30:23];
        return r;
    endfunction

    function automatic addsum_t add_sum(input align_t s);
        logic [5:0]  rs;
        logic [53:0] wide;
        logic [26:0] al;
        addsum_t     r;
        rs     = (s.d > 8'd27) ? 6'd27 : s.d[5:0];
        wide   = {s.msm, 3'b000, 27'b0} >> rs;
        al     = wide[53:27] | {26'b0, |wide[26:0]};
        r.sum  = {1'b0, s.mbig, 3'b000} + {1'b0, al};
        r.ebig = s.ebig;
        r.inf  = s.inf;
        return r;
    endfunction

    function automatic logic [30:0] add_round(input addsum_t s);
        logic [23:0] m;
        logic        g, st, inc;
        logic [8:0]  eeff;
        logic [32:0] pk;
        logic [30:0] r;
        if (s.sum[27])
        begin
            m    = s.sum[27:4];
            g    = s.sum[3];
            st   = |s.sum[2:0];
            eeff = {1'b0, s.ebig} + 9'd1;
        end
        else
        begin
            m    = s.sum[26:3];
            g    = s.sum[2];
            st   = |s.sum[1:0];
            eeff = {1'b0, s.ebig};
        end
        inc = g & (st | m[0]);
        pk  = {1'b0, eeff - 9'd1, 23'b0} + {9'b0, m} + {32'b0, inc};
        if (s.inf || pk >= {2'b0, INF_MAG})
            r = INF_MAG;
        else
            r = pk[30:0];
        return r;
    endfunction

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 24; i++)
        begin
            if (v[i])
                n = 5'(23 - i);
        end
        return n;
    endfunction

    function automatic prep_t sq_prep(input logic [30:0] s);
        logic [4:0]        k;
        logic [23:0]       m;
        logic signed [9:0] e, e2;
        prep_t             r;
        if (s[30:23] == 8'd0)
        begin
            k = lzc24({1'b0, s[22:0]});
            m = {1'b0, s[22:0]} << k;
            e = -10'sd149 - $signed({5'b0, k});
        end
        else
        begin
            m = {1'b1, s[22:0]};
            e = $signed({2'b0, s[30:23]}) - 10'sd150;
        end
        if (e[0])
        begin
            r.big = {1'b0, m, 25'b0};
            e2    = e - 10'sd25;
        end
        else
        begin
            r.big = {m, 26'b0};
            e2    = e - 10'sd26;
        end
        r.rexp = 8'((e2 >>> 1) + 10'sd151);
        r.zero = (s == 31'd0);
        r.inf  = &s[30:23];
        return r;
    endfunction

    align_t      a1_reg, a2_reg;
    addsum_t     s1_reg, s2_reg;
    logic [30:0] r1_reg, r2_reg;
    logic [30:0] sz_d_reg [0:ADD_LAT-1];

    logic [SQ_W-1:0] big_reg  [0:SQ_ITER];
    logic [SQ_W-1:0] res_reg  [0:SQ_ITER];
    logic [7:0]      rexp_reg [0:SQ_ITER];
    logic [SQ_ITER:0] zero_reg;
    logic [SQ_ITER:0] inf_reg;
    logic [30:0]      root_reg;

    logic [SQ_W-1:0] big_next [0:SQ_ITER-1];
    logic [SQ_W-1:0] res_next [0:SQ_ITER-1];
    prep_t           prep;

    logic        guard, sticky, inc;
    logic [24:0] q25;
    logic [30:0] root_next;

    assign prep = sq_prep(r2_reg);

    always_comb
    begin : sq_iter
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] t;
        bitv = '0;
        t    = '0;
        for (int j = 0; j < SQ_ITER; j++)
        begin
            bitv = SQ_W'(1) << (48 - 2 * j);
            t    = res_reg[j] + bitv;
            if (big_reg[j] >= t)
            begin
                big_next[j] = big_reg[j] - t;
                res_next[j] = (res_reg[j] >> 1) + bitv;
            end
            else
            begin
                big_next[j] = big_reg[j];
                res_next[j] = res_reg[j] >> 1;
            end
        end
    end

    always_comb
    begin
        guard  = res_reg[SQ_ITER][0];
        sticky = (big_reg[SQ_ITER] != '0);
        inc    = guard & (sticky | res_reg[SQ_ITER][1]);
        q25    = {1'b0, res_reg[SQ_ITER][24:1]} + {24'b0, inc};
        if (inf_reg[SQ_ITER])
            root_next = INF_MAG;
        else if (zero_reg[SQ_ITER])
            root_next = '0;
        else if (q25[24])
            root_next = {rexp_reg[SQ_ITER] + 8'd1, 23'b0};
        else
            root_next = {rexp_reg[SQ_ITER], q25[22:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg      <= add_align(sx, sy);
            s1_reg      <= add_sum(a1_reg);
            r1_reg      <= add_round(s1_reg);
            sz_d_reg[0] <= sz;
            for (int i = 1; i < ADD_LAT; i++)
                sz_d_reg[i] <= sz_d_reg[i-1];
            a2_reg      <= add_align(r1_reg, sz_d_reg[ADD_LAT-1]);
            s2_reg      <= add_sum(a2_reg);
            r2_reg      <= add_round(s2_reg);

            big_reg[0]  <= {1'b0, prep.big};
            res_reg[0]  <= '0;
            rexp_reg[0] <= prep.rexp;
            zero_reg    <= {zero_reg[SQ_ITER-1:0], prep.zero};
            inf_reg     <= {inf_reg[SQ_ITER-1:0], prep.inf};
            for (int j = 0; j < SQ_ITER; j++)
            begin
                big_reg[j+1]  <= big_next[j];
                res_reg[j+1]  <= res_next[j];
                rexp_reg[j+1] <= rexp_reg[j];
            end
            root_reg <= root_next;
        end
    end

    assign root = root_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/hypot3_float_scaled_unit.sv
// top level: single-precision norm sqrt(x^2+y^2+z^2) with exponent-based pre-scaling
// depends on hyp3_pkg, hyp3_chan_if, hyp3_fmul, hyp3_sumsqrt
//
// usage
//   vec carries requests of three single-precision bit patterns, norm carries
//   one single-precision result per request, in request order
//   an item is taken on a clock edge with valid and ready both high
//   throughput: one request per cycle when not stalled; the pipeline is 43
//   register stages (scale multiply 3, square 3, two adds 3 each, square root
//   27, final scale 3, plus the input stage), each one multiply or one wide add deep
//   stall: a result waiting on norm sits in the output register, one more
//   item is caught in a skid register, then vec.ready drops and the whole
//   pipeline holds; nothing is lost or repeated
//   reset: rst_n clears all valid bits, including those of the output and skid
//   registers; the block takes requests in the first cycle after reset is released
//   NaN operands give 0x7FC00000, infinities give +infinity
`default_nettype none

module hypot3_float_scaled_unit (
    input  logic       clk,
    input  logic       rst_n,
    hyp3_chan_if.sink   vec,
    hyp3_chan_if.source norm
);
    import hyp3_pkg::*;

    logic               en;
    logic [LAST_STG:0]  v_reg;
    logic [LAST_STG:0]  nan_reg;
    scale_t             sel_reg [0:ROOT_OUT];
    logic [30:0]        ax_reg, ay_reg, az_reg;

    logic               skid_v_reg;
    logic [31:0]        skid_d_reg;
    logic               out_v_reg;
    logic [31:0]        out_d_reg;

    logic [30:0]        bx, by, bz, mx;
    logic               nan_in;
    scale_t             sel_in;
    logic [30:0]        pre_k, post_k;
    logic [30:0]        px, py, pz;
    logic [30:0]        sx, sy, sz;
    logic [30:0]        root, scaled;
    logic [31:0]        pipe_d;
    logic               take, emit;

    always_comb
    begin
        bx     = vec.data.x_bits[30:0];
        by     = vec.data.y_bits[30:0];
        bz     = vec.data.z_bits[30:0];
        nan_in = (bx > INF_MAG) || (by > INF_MAG) || (bz > INF_MAG);
        mx     = bx;
        if (by > mx)
            mx = by;
        if (bz > mx)
            mx = bz;
        priority if (mx[30:23] >= HIGH_EXPO)
            sel_in = SC_DOWN;
        else if (mx[30:23] <= LOW_EXPO)
            sel_in = SC_UP;
        else
            sel_in = SC_NONE;
    end

    always_comb
    begin
        unique case (sel_reg[0])
            SC_DOWN: pre_k = SCALE_DOWN;
            SC_UP:   pre_k = SCALE_UP;
            default: pre_k = SCALE_ONE;
        endcase
        unique case (sel_reg[ROOT_OUT])
            SC_DOWN: post_k = SCALE_UP;
            SC_UP:   post_k = SCALE_DOWN;
            default: post_k = SCALE_ONE;
        endcase
    end

    hyp3_fmul u_pre_x (.clk(clk), .en(en), .a(ax_reg), .b(pre_k), .y(px));
    hyp3_fmul u_pre_y (.clk(clk), .en(en), .a(ay_reg), .b(pre_k), .y(py));
    hyp3_fmul u_pre_z (.clk(clk), .en(en), .a(az_reg), .b(pre_k), .y(pz));

    hyp3_fmul u_sq_x (.clk(clk), .en(en), .a(px), .b(px), .y(sx));
    hyp3_fmul u_sq_y (.clk(clk), .en(en), .a(py), .b(py), .y(sy));
    hyp3_fmul u_sq_z (.clk(clk), .en(en), .a(pz), .b(pz), .y(sz));

    hyp3_sumsqrt u_root (
        .clk  (clk),
        .en   (en),
        .sx   (sx),
        .sy   (sy),
        .sz   (sz),
        .root (root)
    );

    hyp3_fmul u_post (.clk(clk), .en(en), .a(root), .b(post_k), .y(scaled));

    assign pipe_d = nan_reg[LAST_STG] ? QNAN_BITS : {1'b0, scaled};
    assign en     = !skid_v_reg;
    assign take   = !out_v_reg || norm.ready;
    assign emit   = en && v_reg[LAST_STG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            skid_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (en)
                v_reg <= {v_reg[LAST_STG-1:0], vec.valid};
            if (take)
            begin
                out_v_reg  <= skid_v_reg | emit;
                skid_v_reg <= 1'b0;
            end
            else if (emit)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg     <= bx;
            ay_reg     <= by;
            az_reg     <= bz;
            nan_reg    <= {nan_reg[LAST_STG-1:0], nan_in};
            sel_reg[0] <= sel_in;
            for (int i = 1; i <= ROOT_OUT; i++)
                sel_reg[i] <= sel_reg[i-1];
        end
        if (take)
            out_d_reg <= skid_v_reg ? skid_d_reg : pipe_d;
        else if (emit)
            skid_d_reg <= pipe_d;
    end

    assign vec.ready      = en;
    assign norm.valid     = out_v_reg;
    assign norm.data      = '{norm_bits: out_d_reg};

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid register holds a result while the output register is empty");

    a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[LAST_STG] && !en) |=> v_reg[LAST_STG])
        else $error("pipeline dropped a finished item while stalled");

    a_canonical_nan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && (&out_d_reg[30:23])) |->
            (out_d_reg[22:0] == 23'd0 || out_d_reg == QNAN_BITS))
        else $error("result is a non-canonical NaN");

    a_sign_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> !out_d_reg[31])
        else $error("result carries a negative sign");

endmodule

`default_nettype wire
